### rtl/core/jqqt_pkg.sv
package jqqt_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int COEF_W        = $clog2(TABLE_ENTRIES);
   localparam int BASE_W        = 7;
   localparam int QUALITY_W     = 8;
   localparam int SCALE_W       = 13;
   localparam int SUM_W         = 20;
   localparam int QUO_W         = 13;
   localparam int VALUE_W       = 15;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = QUALITY_W;

   // divide by 100 as multiply by ceil(2^27 / 100), exact for sums below 2^20
   localparam int RECIP_SHIFT = 27;
   localparam int RECIP_W     = 21;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_100 = 21'd1342178;

   localparam logic [SUM_W-1:0]   ROUND_HALF   = 20'd50;
   localparam logic [QUO_W-1:0]   VALUE_MIN    = 13'd1;
   localparam logic [QUO_W-1:0]   BASELINE_MAX = 13'd255;

   localparam logic [CSR_INDEX_W-1:0] CSR_QUALITY  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASELINE = 1'b1;

   localparam logic [QUALITY_W-1:0] QUALITY_RESET  = 8'd75;
   localparam logic                 BASELINE_RESET = 1'b1;

   typedef struct packed {
      logic [SCALE_W-1:0] scale;
      logic               baseline_cap;
   } cfg_type;

   localparam logic [BASE_W-1:0] LUMA_BASE [TABLE_ENTRIES] = '{
       7'd16,  7'd11,  7'd10,  7'd16,  7'd24,  7'd40,  7'd51,  7'd61,
       7'd12,  7'd12,  7'd14,  7'd19,  7'd26,  7'd58,  7'd60,  7'd55,
       7'd14,  7'd13,  7'd16,  7'd24,  7'd40,  7'd57,  7'd69,  7'd56,
       7'd14,  7'd17,  7'd22,  7'd29,  7'd51,  7'd87,  7'd80,  7'd62,
       7'd18,  7'd22,  7'd37,  7'd56,  7'd68, 7'd109, 7'd103,  7'd77,
       7'd24,  7'd35,  7'd55,  7'd64,  7'd81, 7'd104, 7'd113,  7'd92,
       7'd49,  7'd64,  7'd78,  7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
       7'd72,  7'd92,  7'd95,  7'd98, 7'd112, 7'd100, 7'd103,  7'd99
   };

   localparam logic [BASE_W-1:0] CHROMA_BASE [TABLE_ENTRIES] = '{
       7'd17,  7'd18,  7'd24,  7'd47,  7'd99,  7'd99,  7'd99,  7'd99,
       7'd18,  7'd21,  7'd26,  7'd66,  7'd99,  7'd99,  7'd99,  7'd99,
       7'd24,  7'd26,  7'd56,  7'd99,  7'd99,  7'd99,  7'd99,  7'd99,
       7'd47,  7'd66,  7'd99,  7'd99,  7'd99,  7'd99,  7'd99,  7'd99,
       7'd99,  7'd99,  7'd99,  7'd99,  7'd99,  7'd99,  7'd99,  7'd99,
       7'd99,  7'd99,  7'd99,  7'd99,  7'd99,  7'd99,  7'd99,  7'd99,
       7'd99,  7'd99,  7'd99,  7'd99,  7'd99,  7'd99,  7'd99,  7'd99,
       7'd99,  7'd99,  7'd99,  7'd99,  7'd99,  7'd99,  7'd99,  7'd99
   };

   // 5000 / q for q below 50, entry zero unused
   localparam int SCALE_LOW_ENTRIES = 50;
   localparam logic [SCALE_W-1:0] SCALE_LOW [SCALE_LOW_ENTRIES] = '{
      13'd5000, 13'd5000, 13'd2500, 13'd1666, 13'd1250, 13'd1000, 13'd833, 13'd714,
      13'd625,  13'd555,  13'd500,  13'd454,  13'd416,  13'd384,  13'd357, 13'd333,
      13'd312,  13'd294,  13'd277,  13'd263,  13'd250,  13'd238,  13'd227, 13'd217,
      13'd208,  13'd200,  13'd192,  13'd185,  13'd178,  13'd172,  13'd166, 13'd161,
      13'd156,  13'd151,  13'd147,  13'd142,  13'd138,  13'd135,  13'd131, 13'd128,
      13'd125,  13'd121,  13'd119,  13'd116,  13'd113,  13'd111,  13'd108, 13'd106,
      13'd104,  13'd102
   };

   function automatic logic [SCALE_W-1:0] scale_of(input logic [QUALITY_W-1:0] q);
      logic [6:0]         qc;
      logic [SCALE_W-1:0] s;
      if (q == 8'd0) begin
         qc = 7'd1;
      end else if (q > 8'd100) begin
         qc = 7'd100;
      end else begin
         qc = q[6:0];
      end
      if (qc < 7'd50) begin
         s = SCALE_LOW[qc[5:0]];
      end else begin
         s = 13'd200 - SCALE_W'({qc, 1'b0});
      end
      return s;
   endfunction

endpackage

### rtl/core/jqqt_pipe.sv
module jqqt_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  jqqt_pkg::cfg_type             cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          in_table_select,
   input  logic [jqqt_pkg::COEF_W-1:0]   in_coef_index,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [jqqt_pkg::VALUE_W-1:0]  out_value
);

   // stage 1: rom read
   logic                          v1_ff;
   logic [jqqt_pkg::BASE_W-1:0]   base1_ff, base1_in;
   // stage 2: base * scale + 50
   logic                          v2_ff;
   logic [jqqt_pkg::SUM_W-1:0]    sum2_ff, sum2_in;
   // stage 3: divide by 100
   logic                          v3_ff;
   logic [jqqt_pkg::QUO_W-1:0]    quo3_ff, quo3_in;
   logic [jqqt_pkg::PROD_W-1:0]   prod3;
   // stage 4: clamp, output register
   logic                          v4_ff;
   logic [jqqt_pkg::VALUE_W-1:0]  value4_ff, value4_in;

   logic adv1, adv2, adv3, adv4;

   assign adv4     = !v4_ff || out_ready;
   assign adv3     = !v3_ff || adv4;
   assign adv2     = !v2_ff || adv3;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   assign base1_in = in_table_select ? jqqt_pkg::CHROMA_BASE[in_coef_index]
                                     : jqqt_pkg::LUMA_BASE[in_coef_index];

   assign sum2_in = jqqt_pkg::SUM_W'(base1_ff) * jqqt_pkg::SUM_W'(cfg.scale)
                    + jqqt_pkg::ROUND_HALF;

   assign prod3   = jqqt_pkg::PROD_W'(sum2_ff) * jqqt_pkg::PROD_W'(jqqt_pkg::RECIP_100);
   assign quo3_in = prod3[jqqt_pkg::RECIP_SHIFT +: jqqt_pkg::QUO_W];

   always_comb begin
      // quotient never exceeds 6050, so the 32767 ceiling cannot bind
      if (quo3_ff == '0) begin
         value4_in = jqqt_pkg::VALUE_W'(jqqt_pkg::VALUE_MIN);
      end else if (cfg.baseline_cap && quo3_ff > jqqt_pkg::BASELINE_MAX) begin
         value4_in = jqqt_pkg::VALUE_W'(jqqt_pkg::BASELINE_MAX);
      end else begin
         value4_in = jqqt_pkg::VALUE_W'(quo3_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= in_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && in_valid) base1_ff  <= base1_in;
      if (adv2 && v1_ff)    sum2_ff   <= sum2_in;
      if (adv3 && v2_ff)    quo3_ff   <= quo3_in;
      if (adv4 && v3_ff)    value4_ff <= value4_in;
   end

   assign out_valid = v4_ff;
   assign out_value = value4_ff;

endmodule

### rtl/core/jpeg_quality_quant_table.sv
// Quality-scaled JPEG quantization table entries. Each item names the luminance or
// chrominance standard table and a coefficient position in stored order; the block
// answers with that entry scaled by the configured quality and clamped to 1..32767,
// or to 1..255 while the baseline cap is set. One item is taken every cycle unless a
// stalled output has filled the pipeline; its result passes through four register
// stages: table lookup, scale multiply, reciprocal multiply for the divide by 100, and
// clamp. A stalled output backs the pipeline up without loss. The quality register is
// turned into its scale percentage at write time, so a write applies to every item
// accepted afterwards.
module jpeg_quality_quant_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [jqqt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [jqqt_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_table_select,
   input  logic [jqqt_pkg::COEF_W-1:0]       req_coef_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [jqqt_pkg::VALUE_W-1:0]      rsp_quant_value
);

   logic [jqqt_pkg::SCALE_W-1:0] scale_ff, scale_in;
   logic                         baseline_cap_ff, baseline_cap_in;
   jqqt_pkg::cfg_type            cfg;

   always_comb begin
      scale_in        = scale_ff;
      baseline_cap_in = baseline_cap_ff;
      if (csr_we) begin
         case (csr_index)
            jqqt_pkg::CSR_QUALITY:  scale_in = jqqt_pkg::scale_of(csr_wdata);
            jqqt_pkg::CSR_BASELINE: baseline_cap_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff        <= jqqt_pkg::scale_of(jqqt_pkg::QUALITY_RESET);
         baseline_cap_ff <= jqqt_pkg::BASELINE_RESET;
      end else begin
         scale_ff        <= scale_in;
         baseline_cap_ff <= baseline_cap_in;
      end
   end

   assign cfg.scale        = scale_ff;
   assign cfg.baseline_cap = baseline_cap_ff;

   jqqt_pipe u_pipe (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .in_valid        (req_valid),
      .in_ready        (req_ready),
      .in_table_select (req_table_select),
      .in_coef_index   (req_coef_index),
      .out_valid       (rsp_valid),
      .out_ready       (rsp_ready),
      .out_value       (rsp_quant_value)
   );

endmodule

### rtl/core/jqqt_checker.sv
module jqqt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [jqqt_pkg::VALUE_W-1:0]     rsp_quant_value
);

   // items accepted but not yet delivered
   logic [2:0] outstanding_ff, outstanding_in;

   always_comb begin
      outstanding_in = outstanding_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         outstanding_in = outstanding_ff + 3'd1;
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         outstanding_in = outstanding_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= 3'd0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quant_value))
      else $error("result changed while stalled");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 3'd0)
      else $error("result without an accepted item");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= 3'd4)
      else $error("more items in flight than pipeline stages");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_quant_value != '0 && rsp_quant_value <= 15'd6050)
      else $error("quantizer step out of range");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

endmodule

bind jpeg_quality_quant_table jqqt_checker u_checker (.*);
